// File: rtl/stack_vm_instruction_executor_assert.svh
// Assertion macros for the stack machine RTL.
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SVIE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svie assertion failed");
// Next-cycle implication, checked out of reset.
`define SVIE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svie assertion failed");
`else
`define SVIE_ASSERT_IMP(label, ante, cons)
`define SVIE_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/svie_pkg.sv
// Shared constants, types and decode helpers of the stack machine.
`timescale 1ns / 1ps
package svie_pkg;

  // Default memory depths in words.
  localparam int DEF_CODE_DEPTH  = 4096;
  localparam int DEF_STACK_DEPTH = 1024;
  localparam int DEF_DATA_DEPTH  = 1024;

  // Stream widths.
  localparam int IN_W   = 80;
  localparam int OUT_W  = 80;
  localparam int USER_W = 2;

  // Commands carried in the input tuser.
  localparam logic [1:0] CMD_LOAD_CODE = 2'd0;
  localparam logic [1:0] CMD_LOAD_DATA = 2'd1;
  localparam logic [1:0] CMD_EXEC      = 2'd2;

  // Print event kinds carried in the output tuser.
  localparam logic [1:0] PK_NONE    = 2'd0;
  localparam logic [1:0] PK_NUMBER  = 2'd1;
  localparam logic [1:0] PK_NEWLINE = 2'd2;
  localparam logic [1:0] PK_SPACE   = 2'd3;

  // Instruction opcodes; zero never names a valid instruction.
  localparam logic [5:0] OP_NONE  = 6'd0;
  localparam logic [5:0] OP_PUSH  = 6'd13;
  localparam logic [5:0] OP_POP   = 6'd14;
  localparam logic [5:0] OP_SET   = 6'd15;
  localparam logic [5:0] OP_INC   = 6'd16;
  localparam logic [5:0] OP_DEC   = 6'd17;
  localparam logic [5:0] OP_JMP   = 6'd18;
  localparam logic [5:0] OP_JZ    = 6'd19;
  localparam logic [5:0] OP_MOV   = 6'd20;
  localparam logic [5:0] OP_ADD   = 6'd21;
  localparam logic [5:0] OP_SUB   = 6'd22;
  localparam logic [5:0] OP_MUL   = 6'd23;
  localparam logic [5:0] OP_DIV   = 6'd24;
  localparam logic [5:0] OP_MOD   = 6'd25;
  localparam logic [5:0] OP_ASS   = 6'd26;
  localparam logic [5:0] OP_EQ    = 6'd27;
  localparam logic [5:0] OP_HIG   = 6'd28;
  localparam logic [5:0] OP_LOW   = 6'd29;
  localparam logic [5:0] OP_AND   = 6'd30;
  localparam logic [5:0] OP_OR    = 6'd31;
  localparam logic [5:0] OP_NOT   = 6'd32;
  localparam logic [5:0] OP_AG    = 6'd33;
  localparam logic [5:0] OP_AL    = 6'd34;
  localparam logic [5:0] OP_VAL   = 6'd35;
  localparam logic [5:0] OP_EXIT  = 6'd36;
  localparam logic [5:0] OP_PRINT = 6'd37;
  localparam logic [5:0] OP_ENDL  = 6'd38;
  localparam logic [5:0] OP_SPACE = 6'd39;
  localparam logic [5:0] OP_SCAN  = 6'd40;

  // Pointer bit that selects data memory.
  localparam logic [31:0] DATA_SEL = 32'h0001_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic fop;
    logic fa1;
    logic fa2;
    logic rd1;
    logic rd2;
    logic chk;
    logic div_start;
    logic wb;
    logic set_fault;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic halted;
    logic fault_fop;
    logic fault_fa1;
    logic fault_chk;
    logic is_div;
    logic div_done;
  } sts_t;

  // Short opcode of a code word; large words decode as no opcode.
  function automatic logic [5:0] op_code(input logic [31:0] w);
    op_code = (w[31:6] != 26'd0) ? OP_NONE : w[5:0];
  endfunction

  // Instruction length in words.
  function automatic logic [1:0] op_len(input logic [31:0] w);
    logic [5:0] c;
    c = op_code(w);
    case (c) inside
      OP_SET, OP_INC, OP_DEC, OP_MOV:               op_len = 2'd3;
      OP_PUSH, OP_POP, OP_JMP, OP_JZ, OP_AG, OP_AL: op_len = 2'd2;
      default:                                      op_len = 2'd1;
    endcase
  endfunction

endpackage

// File: rtl/svie_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
module svie_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/svie_div.sv
// Bit-serial signed divider giving quotient and remainder.
`timescale 1ns / 1ps
module svie_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dvd,
  input  logic [31:0] dvs,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  localparam logic [5:0] STEPS = 6'd32;

  logic [5:0]  cnt_r;
  logic [31:0] q_r, r_r, d_r;
  logic        nq_r, nr_r;
  logic [32:0] t, diff;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign t    = {r_r, q_r[31]};
  assign diff = t - {1'b0, d_r};

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= STEPS;
    end else if (cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  // Magnitude registers; signs are restored at the output.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r  <= dvd[31] ? -dvd : dvd;
      d_r  <= dvs[31] ? -dvs : dvs;
      r_r  <= '0;
      nq_r <= dvd[31] ^ dvs[31];
      nr_r <= dvd[31];
    end else if (cnt_r != 6'd0) begin
      if (!diff[32]) begin
        r_r <= diff[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= t[31:0];
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign done = (cnt_r == 6'd0);
  assign quot = nq_r ? -q_r : q_r;
  assign rem  = nr_r ? -r_r : r_r;
endmodule

// File: rtl/svie_ctrl.sv
// Sequencer of the stack machine: clearing, command intake, execute steps, result.
`timescale 1ns / 1ps
`include "stack_vm_instruction_executor_assert.svh"
module svie_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  svie_pkg::sts_t       sts,
  output svie_pkg::cmd_t       cmd
);
  import svie_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FOP, S_FA1, S_FA2, S_RD1, S_RD2, S_CHK, S_DIV, S_WB, S_OUT
  } state_t;

  state_t state_r;
  logic   out_tvalid_r;
  logic   out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  // State register and result-valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      // The flag is set when a result is loaded and cleared when it is taken.
      if (state_r == S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: if (sts.clear_done) state_r <= S_IDLE;
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= (in_tuser == CMD_EXEC && !sts.halted) ? S_FOP : S_OUT;
          end
        end
        S_FOP: state_r <= sts.fault_fop ? S_OUT : S_FA1;
        S_FA1: state_r <= sts.fault_fa1 ? S_OUT : S_FA2;
        S_FA2: state_r <= S_RD1;
        S_RD1: state_r <= S_RD2;
        S_RD2: state_r <= S_CHK;
        S_CHK: begin
          if (sts.fault_chk) begin
            state_r <= S_OUT;
          end else begin
            state_r <= sts.is_div ? S_DIV : S_WB;
          end
        end
        S_DIV: if (sts.div_done) state_r <= S_WB;
        S_WB:  state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd        = '0;
    cmd.clear  = (state_r == S_CLEAR);
    cmd.accept = (state_r == S_IDLE) && in_tvalid;
    cmd.fop    = (state_r == S_FOP);
    cmd.fa1    = (state_r == S_FA1);
    cmd.fa2    = (state_r == S_FA2);
    cmd.rd1    = (state_r == S_RD1);
    cmd.rd2    = (state_r == S_RD2);
    cmd.chk    = (state_r == S_CHK);
    cmd.wb     = (state_r == S_WB);
    cmd.div_start = (state_r == S_CHK) && !sts.fault_chk && sts.is_div;
    cmd.set_fault = ((state_r == S_FOP) && sts.fault_fop) ||
                    ((state_r == S_FA1) && sts.fault_fa1) ||
                    ((state_r == S_CHK) && sts.fault_chk);
    cmd.out_load  = (state_r == S_OUT) && out_free;
  end

  // Commands are taken only once memories are cleared.
  `SVIE_ASSERT_IMP(a_accept_after_clear, in_tvalid && in_tready, sts.clear_done)
  // A halted machine never runs the divider.
  `SVIE_ASSERT_IMP(a_no_div_when_halted, state_r == S_DIV, !sts.halted)
  // Write-back is always followed by the result stage.
  `SVIE_ASSERT_NXT(a_wb_then_out, cmd.wb, state_r == S_OUT)
endmodule

// File: rtl/svie_dp.sv
// Datapath of the stack machine: registers, memories, decode, ALU and divider.
`timescale 1ns / 1ps
module svie_dp #(
  parameter int CODE_DEPTH  = svie_pkg::DEF_CODE_DEPTH,
  parameter int STACK_DEPTH = svie_pkg::DEF_STACK_DEPTH,
  parameter int DATA_DEPTH  = svie_pkg::DEF_DATA_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  svie_pkg::cmd_t              cmd,
  output svie_pkg::sts_t              sts,
  input  logic [svie_pkg::IN_W-1:0]   in_tdata,
  input  logic [1:0]                  in_tuser,
  output logic [svie_pkg::OUT_W-1:0]  out_tdata,
  output logic [1:0]                  out_tuser
);
  import svie_pkg::*;

  localparam int CAW  = $clog2(CODE_DEPTH);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int DAW  = $clog2(DATA_DEPTH);
  localparam int MAXD = (STACK_DEPTH > DATA_DEPTH) ? STACK_DEPTH : DATA_DEPTH;
  localparam int CLW  = $clog2(MAXD + 1);
  localparam logic [31:0] CD32 = 32'(CODE_DEPTH);
  localparam logic [31:0] SD32 = 32'(STACK_DEPTH);
  localparam logic [31:0] DD32 = 32'(DATA_DEPTH);

  typedef enum logic [1:0] {RS_REG, RS_STK, RS_DAT} rsrc_t;

  // Out-of-range pointer test for stack or data memory.
  function automatic logic cell_bad(input logic [31:0] a);
    logic [31:0] di;
    di = a & ~DATA_SEL;
    cell_bad = a[16] ? (di >= DD32) : (a >= SD32);
  endfunction

  // Input fields.
  logic [11:0] la;
  logic [31:0] lv, sv, la32;
  assign la   = in_tdata[11:0];
  assign lv   = in_tdata[43:12];
  assign sv   = in_tdata[75:44];
  assign la32 = {20'd0, la};

  // Architectural registers IP, BP, SP, AX and execute scratch.
  logic [31:0] rg_r [4];
  logic [31:0] rg_nxt [4];
  logic [31:0] op_r, a1_r, a2_r, left_r, opnd_r, scan_r;
  logic [1:0]  len_r;
  logic        halt_r, fault_r;
  logic [1:0]  kind_r;
  logic [31:0] pval_r;
  logic [CLW-1:0] clr_r;
  rsrc_t       rsrc_r;
  logic [1:0]  rreg_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  logic [31:0] ip, sp, ax, ipl;
  logic [5:0]  code;
  logic        pops;
  assign ip   = rg_r[0];
  assign sp   = rg_r[2];
  assign ax   = rg_r[3];
  assign ipl  = ip + {30'd0, len_r};
  assign code = op_code(op_r);
  assign pops = (code >= OP_ADD && code <= OP_OR) || code == OP_PRINT;

  // Memories.
  logic            code_we, stk_we, dat_we;
  logic [CAW-1:0]  code_waddr, code_raddr;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [DAW-1:0]  dat_waddr, dat_raddr;
  logic [31:0]     code_rdata, stk_rdata, dat_rdata, stk_wdata, dat_wdata;

  svie_ram #(.W(32), .DEPTH(CODE_DEPTH)) u_code (
    .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(lv),
    .raddr(code_raddr), .rdata(code_rdata));
  svie_ram #(.W(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));
  svie_ram #(.W(32), .DEPTH(DATA_DEPTH)) u_data (
    .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
    .raddr(dat_raddr), .rdata(dat_rdata));

  // Divider.
  logic        div_done;
  logic [31:0] quot, rem;
  svie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dvd(left_r), .dvs(ax),
    .done(div_done), .quot(quot), .rem(rem));

  // Code fetch address: IP, IP+1 and IP+2 in turn, in states FOP, FA1 and FA2.
  logic [31:0] code_ra32;
  assign code_ra32  = ip + (cmd.fa1 ? 32'd1 : (cmd.fa2 ? 32'd2 : 32'd0));
  assign code_raddr = code_ra32[CAW-1:0];
  assign code_we    = cmd.accept && in_tuser == CMD_LOAD_CODE && la32 < CD32;
  assign code_waddr = la32[CAW-1:0];

  // Operand read: popped word first, then the pointer operand.
  logic [31:0] rd_addr, rd_didx, rd_val, reg_val;
  always_comb begin
    if (cmd.rd1) begin
      rd_addr = sp - 32'd1;
    end else if (code == OP_MOV) begin
      rd_addr = a2_r;
    end else if (code == OP_VAL) begin
      rd_addr = ax;
    end else begin
      rd_addr = a1_r;
    end
  end
  assign rd_didx   = rd_addr & ~DATA_SEL;
  assign stk_raddr = rd_addr[SAW-1:0];
  assign dat_raddr = rd_didx[DAW-1:0];

  always_ff @(posedge clk) begin
    if (rd_addr[16]) begin
      rsrc_r <= RS_DAT;
    end else if (rd_addr < 32'd4) begin
      rsrc_r <= RS_REG;
    end else begin
      rsrc_r <= RS_STK;
    end
    rreg_r <= rd_addr[1:0];
  end

  // The pointer operand sees IP already advanced past the instruction.
  assign reg_val = (rreg_r == 2'd0 && cmd.chk) ? ipl : rg_r[rreg_r];
  always_comb begin
    case (rsrc_r)
      RS_STK:  rd_val = stk_rdata;
      RS_DAT:  rd_val = dat_rdata;
      default: rd_val = reg_val;
    endcase
  end

  // Fault checks once all operands are known.
  logic a1_bad, a2_bad, pop_bad, fault_chk;
  assign a1_bad  = a1_r >= SD32;
  assign a2_bad  = a2_r >= SD32;
  assign pop_bad = (sp == 32'd0) || (sp - 32'd1 >= SD32);
  always_comb begin
    fault_chk = pops && pop_bad;
    unique case (code) inside
      OP_PUSH:                fault_chk = a1_bad || sp >= SD32;
      OP_POP:                 fault_chk = a1_bad || pop_bad;
      OP_SET, OP_INC, OP_DEC: fault_chk = a1_bad;
      OP_MOV:                 fault_chk = a1_bad || a2_bad;
      OP_DIV, OP_MOD:         fault_chk = fault_chk || ax == 32'd0;
      OP_ASS:                 fault_chk = fault_chk || cell_bad(left_r);
      OP_VAL:                 fault_chk = cell_bad(ax);
      default:                fault_chk = fault_chk;
    endcase
  end

  // Write-back values.
  logic [31:0] ipn, spn, maddr, mdat, axv, mdidx;
  logic        sp_chg, mwe, mlast, axw, m_reg;
  always_comb begin
    ipn = ipl; spn = sp; sp_chg = 1'b0;
    mwe = 1'b0; maddr = a1_r; mdat = opnd_r; mlast = 1'b0;
    axw = 1'b1; axv = ax;
    if (pops) begin
      spn    = sp - 32'd1;
      sp_chg = 1'b1;
    end
    unique case (code)
      OP_PUSH: begin
        mwe = 1'b1; maddr = sp; spn = sp + 32'd1; sp_chg = 1'b1; axw = 1'b0;
      end
      OP_POP: begin
        mwe = 1'b1; mdat = left_r; mlast = 1'b1; spn = sp - 32'd1; sp_chg = 1'b1;
        axw = 1'b0;
      end
      OP_SET:  begin mwe = 1'b1; mdat = a2_r; axw = 1'b0; end
      OP_INC:  begin mwe = 1'b1; mdat = opnd_r + a2_r; axw = 1'b0; end
      OP_DEC:  begin mwe = 1'b1; mdat = opnd_r - a2_r; axw = 1'b0; end
      OP_MOV:  begin mwe = 1'b1; axw = 1'b0; end
      OP_JMP:  begin ipn = a1_r; axw = 1'b0; end
      OP_JZ:   begin ipn = (ax == 32'd0) ? a1_r : ipl; axw = 1'b0; end
      OP_ASS:  begin mwe = 1'b1; maddr = left_r; mdat = ax; mlast = 1'b1; axw = 1'b0; end
      OP_ADD:  axv = left_r + ax;
      OP_SUB:  axv = left_r - ax;
      OP_MUL:  axv = left_r * ax;
      OP_DIV:  axv = quot;
      OP_MOD:  axv = rem;
      OP_EQ:   axv = {31'd0, left_r == ax};
      OP_HIG:  axv = {31'd0, $signed(left_r) > $signed(ax)};
      OP_LOW:  axv = {31'd0, $signed(left_r) < $signed(ax)};
      OP_AND:  axv = {31'd0, left_r != 32'd0 && ax != 32'd0};
      OP_OR:   axv = {31'd0, left_r != 32'd0 || ax != 32'd0};
      OP_NOT:  axv = {31'd0, ax == 32'd0};
      OP_AG:   axv = DATA_SEL + a1_r;
      OP_AL:   axv = rg_r[1] + a1_r;
      OP_VAL:  axv = opnd_r;
      OP_SCAN: axv = scan_r;
      default: axw = 1'b0;
    endcase
  end
  assign mdidx = maddr & ~DATA_SEL;
  assign m_reg = !maddr[16] && maddr < 32'd4;

  // Register file next values in the order the instruction updates them.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rg_nxt[i] = rg_r[i];
    end
    if (cmd.wb) begin
      rg_nxt[0] = ipn;
      if (mwe && m_reg && !mlast) rg_nxt[maddr[1:0]] = mdat;
      if (sp_chg) rg_nxt[2] = spn;
      if (mwe && m_reg && mlast) rg_nxt[maddr[1:0]] = mdat;
      if (axw) rg_nxt[3] = axv;
    end
  end

  // Clearing pass and write ports of stack and data memory.
  logic clear_done;
  assign clear_done = (clr_r == CLW'(MAXD));
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = maddr[SAW-1:0];
    stk_wdata = mdat;
    dat_we    = 1'b0;
    dat_waddr = mdidx[DAW-1:0];
    dat_wdata = mdat;
    if (cmd.clear) begin
      stk_we    = !clear_done && (32'(clr_r) < SD32);
      stk_waddr = clr_r[SAW-1:0];
      stk_wdata = '0;
      dat_we    = !clear_done && (32'(clr_r) < DD32);
      dat_waddr = clr_r[DAW-1:0];
      dat_wdata = '0;
    end else if (cmd.accept) begin
      dat_we    = in_tuser == CMD_LOAD_DATA && la32 < DD32;
      dat_waddr = la32[DAW-1:0];
      dat_wdata = lv;
    end else if (cmd.wb) begin
      stk_we = mwe && !maddr[16] && !m_reg;
      dat_we = mwe && maddr[16];
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rg_r[0] <= 32'd0;
      rg_r[1] <= 32'd4;
      rg_r[2] <= 32'd4;
      rg_r[3] <= 32'd0;
      halt_r  <= 1'b0;
      clr_r   <= '0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        rg_r[i] <= rg_nxt[i];
      end
      if (cmd.wb && code == OP_EXIT) halt_r <= 1'b1;
      if (cmd.clear && !clear_done) clr_r <= clr_r + CLW'(1);
    end
  end

  // Per-item scratch and result registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fault_r <= 1'b0;
      kind_r  <= PK_NONE;
      pval_r  <= '0;
      scan_r  <= sv;
    end
    if (cmd.set_fault) fault_r <= 1'b1;
    if (cmd.fa1) begin
      op_r  <= code_rdata;
      len_r <= op_len(code_rdata);
    end
    if (cmd.fa2) a1_r   <= code_rdata;
    if (cmd.rd1) a2_r   <= code_rdata;
    if (cmd.rd2) left_r <= rd_val;
    if (cmd.chk) opnd_r <= rd_val;
    if (cmd.wb) begin
      unique case (code)
        OP_PRINT: begin kind_r <= PK_NUMBER; pval_r <= left_r; end
        OP_ENDL:  kind_r <= PK_NEWLINE;
        OP_SPACE: kind_r <= PK_SPACE;
        default:  kind_r <= PK_NONE;
      endcase
    end
    if (cmd.out_load) begin
      out_tuser_r <= kind_r;
      out_tdata_r <= {2'd0, ax, ip[11:0], fault_r, halt_r, pval_r};
    end
  end

  // Status to the controller.
  always_comb begin
    sts.clear_done = clear_done;
    sts.halted     = halt_r;
    sts.fault_fop  = ip >= CD32;
    sts.fault_fa1  = ip > (CD32 - {30'd0, op_len(code_rdata)});
    sts.fault_chk  = fault_chk;
    sts.is_div     = (code == OP_DIV) || (code == OP_MOD);
    sts.div_done   = div_done;
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;
endmodule

// File: rtl/stack_vm_instruction_executor.sv
// Top level of the stack bytecode machine.
`timescale 1ns / 1ps
// Runs one command beat at a time and returns one result beat for each. After
// reset the stack and data memories are swept to zero, one word per cycle, over
// the larger of STACK_DEPTH and DATA_DEPTH (1024 words by default) before the
// first beat is taken. Loads go straight to the result stage after acceptance,
// and so do execute commands on a halted machine. An executed instruction runs
// from acceptance to result in steps: up to three code words come through the
// single code-memory read port one per cycle, then the popped word and the
// pointer operand are read through the stack and data memory ports, then the
// write-back. DIV and MOD also wait for the bit-serial divider. A fault is
// found before write-back and ends the instruction early with no state change.
// A finished result waits in the output register while the next beat is taken.
module stack_vm_instruction_executor #(
  parameter int CODE_DEPTH  = svie_pkg::DEF_CODE_DEPTH,
  parameter int STACK_DEPTH = svie_pkg::DEF_STACK_DEPTH,
  parameter int DATA_DEPTH  = svie_pkg::DEF_DATA_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // load_address[11:0], load_value[43:12], scan_value[75:44], zero pad
  input  logic [svie_pkg::IN_W-1:0]   in_tdata,
  // opcode[1:0]
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // print_value[31:0], halted[32], fault[33], next_ip[45:34],
  // accumulator[77:46], zero pad
  output logic [svie_pkg::OUT_W-1:0]  out_tdata,
  // print_kind[1:0]
  output logic [1:0]                  out_tuser
);
  import svie_pkg::*;

  cmd_t cmd;
  sts_t sts;

  svie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .cmd(cmd));

  svie_dp #(
    .CODE_DEPTH(CODE_DEPTH), .STACK_DEPTH(STACK_DEPTH), .DATA_DEPTH(DATA_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tdata(out_tdata), .out_tuser(out_tuser));
endmodule

// File: tb/tb_stack_vm_instruction_executor.sv
// Self-checking testbench for the stack bytecode machine, with its own predictor.
`timescale 1ns / 1ps
module tb_stack_vm_instruction_executor;
  import svie_pkg::*;

  localparam int CODE_N  = DEF_CODE_DEPTH;
  localparam int STK_N   = DEF_STACK_DEPTH;
  localparam int DATA_N  = DEF_DATA_DEPTH;
  localparam int N_ITEMS = 1600;
  // Slowest beat: a divide plus long stalls and gaps, plus the clear.
  localparam int LIMIT   = 2_000_000;
  // Keep IP below this during the random part so it can always come back.
  localparam logic [31:0] IP_SAFE = 32'd4000;

  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] addr;
    logic [31:0] lval;
    logic [31:0] sval;
    bit          drain;
  } cmd_beat_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] pval;
    logic        halted;
    logic        fault;
    logic [11:0] nip;
    logic [31:0] ax;
  } vm_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic [1:0]        in_tuser = 2'd0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic [1:0]        out_tuser;

  stack_vm_instruction_executor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Machine state as the predictor sees it.
  logic [31:0] vm_stack [STK_N];
  logic [31:0] vm_data  [DATA_N];
  logic [31:0] vm_code  [CODE_N];
  bit          vm_code_ok [CODE_N];
  bit          vm_halted;
  logic [31:0] saved_stack [STK_N];
  logic [31:0] saved_data  [DATA_N];
  bit          saved_halted;

  cmd_beat_t  command_q [$];
  vm_result_t vm_outcome_q [$];

  int  sent_cnt = 0;
  int  got_cnt = 0;
  int  total_beats = 0;
  int  mismatches = 0;
  int  n_exec = 0, n_fault = 0, n_print = 0, n_load = 0;
  bit  last_fault = 1'b0;
  bit  drain_next = 1'b0;
  bit  drain_used = 1'b0;
  longint cycles = 0;

  function automatic int unsigned vm_len(input logic [31:0] op);
    case (op)
      OP_SET, OP_INC, OP_DEC, OP_MOV:               return 3;
      OP_PUSH, OP_POP, OP_JMP, OP_JZ, OP_AG, OP_AL: return 2;
      default:                                      return 1;
    endcase
  endfunction

  // A pointer with the data select bit goes to data memory, else to the stack.
  function automatic bit ptr_ok(input logic [31:0] a);
    if (a[16]) return (a & ~DATA_SEL) < DATA_N;
    return a < STK_N;
  endfunction

  function automatic logic [31:0] ptr_rd(input logic [31:0] a);
    if (a[16]) return vm_data[a & ~DATA_SEL];
    return vm_stack[a];
  endfunction

  function automatic void vm_reset();
    for (int i = 0; i < STK_N; i++) vm_stack[i] = '0;
    for (int i = 0; i < DATA_N; i++) vm_data[i] = '0;
    for (int i = 0; i < CODE_N; i++) begin
      vm_code[i] = '0;
      vm_code_ok[i] = 1'b0;
    end
    vm_stack[1] = 32'd4;
    vm_stack[2] = 32'd4;
    vm_halted = 1'b0;
  endfunction

  // One instruction; returns 1 on a fault, in which case nothing changed.
  function automatic bit vm_exec(input logic [31:0] scan, output logic [1:0] kind,
                                 output logic [31:0] pval);
    logic [31:0] ip, op, a1, a2, sp, left, right, nip, res;
    int unsigned len;
    bit          bin;
    longint      q;
    kind = PK_NONE;
    pval = '0;
    a1 = '0;
    a2 = '0;
    left = '0;
    ip = vm_stack[0];
    if (ip >= CODE_N) return 1;
    op = vm_code[ip];
    len = vm_len(op);
    if (ip > CODE_N - len) return 1;
    if (len > 1) a1 = vm_code[ip + 1];
    if (len > 2) a2 = vm_code[ip + 2];
    nip = ip + len;
    sp = vm_stack[2];
    bin = (op >= OP_ADD && op <= OP_OR);
    if (bin || op == OP_PRINT) begin
      if (sp == 0 || sp - 1 >= STK_N) return 1;
      left = vm_stack[sp - 1];
    end
    right = vm_stack[3];

    // Register-style instructions finish here; others only check for faults.
    case (op)
      OP_PUSH: begin
        if (a1 >= STK_N || sp >= STK_N) return 1;
        res = (a1 == 0) ? nip : vm_stack[a1];
        vm_stack[0] = nip;
        vm_stack[sp] = res;
        vm_stack[2] = sp + 1;
        return 0;
      end
      OP_POP: begin
        if (a1 >= STK_N || sp == 0 || sp - 1 >= STK_N) return 1;
        res = vm_stack[sp - 1];
        vm_stack[0] = nip;
        vm_stack[2] = sp - 1;
        vm_stack[a1] = res;
        return 0;
      end
      OP_SET, OP_INC, OP_DEC: begin
        if (a1 >= STK_N) return 1;
        vm_stack[0] = nip;
        if (op == OP_SET) vm_stack[a1] = a2;
        else if (op == OP_INC) vm_stack[a1] = vm_stack[a1] + a2;
        else vm_stack[a1] = vm_stack[a1] - a2;
        return 0;
      end
      OP_MOV: begin
        if (a1 >= STK_N || a2 >= STK_N) return 1;
        vm_stack[0] = nip;
        vm_stack[a1] = vm_stack[a2];
        return 0;
      end
      OP_DIV, OP_MOD: if (right == 0) return 1;
      OP_ASS: if (!ptr_ok(left)) return 1;
      OP_VAL: if (!ptr_ok(right)) return 1;
      default: ;
    endcase

    vm_stack[0] = nip;
    if (bin || op == OP_PRINT) vm_stack[2] = sp - 1;
    case (op)
      OP_JMP: vm_stack[0] = a1;
      OP_JZ:  if (vm_stack[3] == 0) vm_stack[0] = a1;
      OP_ADD: vm_stack[3] = left + right;
      OP_SUB: vm_stack[3] = left - right;
      OP_MUL: vm_stack[3] = left * right;
      OP_DIV: begin
        q = longint'($signed(left)) / longint'($signed(right));
        vm_stack[3] = q[31:0];
      end
      OP_MOD: begin
        q = longint'($signed(left)) % longint'($signed(right));
        vm_stack[3] = q[31:0];
      end
      OP_ASS: begin
        if (left[16]) vm_data[left & ~DATA_SEL] = right;
        else vm_stack[left] = right;
      end
      OP_EQ:  vm_stack[3] = (left == right) ? 32'd1 : 32'd0;
      OP_HIG: vm_stack[3] = ($signed(left) > $signed(right)) ? 32'd1 : 32'd0;
      OP_LOW: vm_stack[3] = ($signed(left) < $signed(right)) ? 32'd1 : 32'd0;
      OP_AND: vm_stack[3] = (left != 0 && right != 0) ? 32'd1 : 32'd0;
      OP_OR:  vm_stack[3] = (left != 0 || right != 0) ? 32'd1 : 32'd0;
      OP_NOT: vm_stack[3] = (vm_stack[3] == 0) ? 32'd1 : 32'd0;
      OP_AG:  vm_stack[3] = DATA_SEL + a1;
      OP_AL:  vm_stack[3] = vm_stack[1] + a1;
      OP_VAL: vm_stack[3] = ptr_rd(right);
      OP_EXIT: vm_halted = 1'b1;
      OP_PRINT: begin
        kind = PK_NUMBER;
        pval = left;
      end
      OP_ENDL:  kind = PK_NEWLINE;
      OP_SPACE: kind = PK_SPACE;
      OP_SCAN:  vm_stack[3] = scan;
      default: ;
    endcase
    return 0;
  endfunction

  function automatic vm_result_t vm_step(input cmd_beat_t b);
    vm_result_t r;
    bit         f;
    r.kind = PK_NONE;
    r.pval = '0;
    f = 1'b0;
    case (b.cmd)
      CMD_LOAD_CODE: begin
        vm_code[b.addr] = b.lval;
        vm_code_ok[b.addr] = 1'b1;
      end
      CMD_LOAD_DATA: if (b.addr < DATA_N) vm_data[b.addr] = b.lval;
      CMD_EXEC: begin
        if (!vm_halted) begin
          f = vm_exec(b.sval, r.kind, r.pval);
          if (f) begin
            r.kind = PK_NONE;
            r.pval = '0;
          end
        end
      end
      default: ;
    endcase
    r.halted = vm_halted;
    r.fault = f;
    r.nip = vm_stack[0][11:0];
    r.ax = vm_stack[3];
    return r;
  endfunction

  // Values that favor edges, small numbers and data pointers.
  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 20);
      6, 7:             return 32'hFFFF_FFFF;
      8, 9:             return 32'h8000_0000;
      10, 11:           return 32'h7FFF_FFFF;
      12, 13, 14:       return DATA_SEL + $urandom_range(0, 40);
      default:          return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(0, 19))
      0, 1, 2:  return $urandom_range(0, 15);
      3, 4:     return $urandom_range(4, 40);
      5:        return ($urandom_range(0, 1) != 0) ? $urandom_range(1020, 1030) : $urandom;
      default:  return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic logic [31:0] pick_op();
    logic [31:0] op;
    case ($urandom_range(0, 19))
      0:       op = $urandom_range(0, 12);
      1:       op = $urandom;
      2:       op = $urandom_range(41, 63);
      default: op = $urandom_range(OP_PUSH, OP_SCAN);
    endcase
    // Halting is saved for the end of the run.
    if (op == OP_EXIT) op = OP_PRINT;
    return op;
  endfunction

  function automatic void push_beat(input cmd_beat_t b);
    vm_result_t r;
    r = vm_step(b);
    command_q.push_back(b);
    vm_outcome_q.push_back(r);
  endfunction

  function automatic void load_word(input logic [1:0] cmd, input logic [11:0] addr,
                                    input logic [31:0] val);
    cmd_beat_t b;
    b.cmd = cmd;
    b.addr = addr;
    b.lval = val;
    b.sval = $urandom;
    b.drain = 1'b0;
    push_beat(b);
    n_load++;
  endfunction

  // Writes a fresh random instruction with sensible operands at ip.
  function automatic void plant(input logic [31:0] ip);
    logic [31:0] op, a1, a2;
    op = pick_op();
    a1 = pick_reg();
    a2 = pick_val();
    case (op)
      OP_JMP, OP_JZ: a1 = ($urandom_range(0, 9) == 0) ? $urandom_range(3990, 4095)
                                                       : $urandom_range(0, 3999);
      OP_AG: a1 = ($urandom_range(0, 4) == 0) ? $urandom_range(1020, 1030)
                                              : $urandom_range(0, 63);
      OP_AL: a1 = $urandom_range(0, 30);
      OP_MOV: a2 = pick_reg();
      OP_SET, OP_INC, OP_DEC: begin
        if (a1 == 0) a2 = $urandom_range(0, 3000);
        else if (a1 == 2 && $urandom_range(0, 7) != 0) a2 = $urandom_range(1, 60);
      end
      default: ;
    endcase
    load_word(CMD_LOAD_CODE, ip[11:0], op);
    if (vm_len(op) > 1 && ip + 1 < CODE_N) load_word(CMD_LOAD_CODE, ip[11:0] + 12'd1, a1);
    if (vm_len(op) > 2 && ip + 2 < CODE_N) load_word(CMD_LOAD_CODE, ip[11:0] + 12'd2, a2);
  endfunction

  // One execute beat; with guard set, a step that would strand IP or halt is undone.
  function automatic bit run_step(input bit guard);
    cmd_beat_t  b;
    vm_result_t r;
    b.cmd = CMD_EXEC;
    b.addr = $urandom;
    b.lval = $urandom;
    b.sval = pick_val();
    b.drain = 1'b0;
    saved_stack = vm_stack;
    saved_data = vm_data;
    saved_halted = vm_halted;
    r = vm_step(b);
    if (guard && (vm_stack[0] >= IP_SAFE || vm_halted)) begin
      vm_stack = saved_stack;
      vm_data = saved_data;
      vm_halted = saved_halted;
      return 0;
    end
    if (drain_next) begin
      b.drain = 1'b1;
      drain_next = 1'b0;
    end
    command_q.push_back(b);
    vm_outcome_q.push_back(r);
    n_exec++;
    if (r.fault) n_fault++;
    if (r.kind != PK_NONE) n_print++;
    last_fault = r.fault;
    return 1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result();
    vm_result_t e;
    if (vm_outcome_q.size() == 0) begin
      flag_mismatch("result beat with nothing expected");
      return;
    end
    e = vm_outcome_q.pop_front();
    if (out_tuser !== e.kind)
      flag_mismatch($sformatf("print_kind %0d, expected %0d", out_tuser, e.kind));
    if (out_tdata[31:0] !== e.pval)
      flag_mismatch($sformatf("print_value %h, expected %h", out_tdata[31:0], e.pval));
    if (out_tdata[32] !== e.halted)
      flag_mismatch($sformatf("halted %b, expected %b", out_tdata[32], e.halted));
    if (out_tdata[33] !== e.fault)
      flag_mismatch($sformatf("fault %b, expected %b", out_tdata[33], e.fault));
    if (out_tdata[45:34] !== e.nip)
      flag_mismatch($sformatf("next_ip %h, expected %h", out_tdata[45:34], e.nip));
    if (out_tdata[77:46] !== e.ax)
      flag_mismatch($sformatf("accumulator %h, expected %h", out_tdata[77:46], e.ax));
  endtask

  // Sender: bursts of beats separated by random gaps; a drain beat waits for all results.
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) sent_cnt <= sent_cnt + 1;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (command_q.size() != 0 &&
                   !(command_q[0].drain && (in_tvalid || sent_cnt != got_cnt))) begin
        in_tvalid <= 1'b1;
        in_tdata <= {4'd0, command_q[0].sval, command_q[0].lval, command_q[0].addr};
        in_tuser <= command_q[0].cmd;
        void'(command_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result beat and stalls in modes that change now and then.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_cnt <= got_cnt + 1;
        check_result();
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) != 0);
        2:       out_tready <= ($urandom_range(0, 5) == 0);
        default: out_tready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_stack_vm_instruction_executor: FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] ip;
    int          tries;
    bit          fresh;
    vm_reset();

    // Directed: data extremes and out-of-range addresses, then a signed-divide program.
    load_word(CMD_LOAD_DATA, 12'd0, 32'h8000_0000);
    load_word(CMD_LOAD_DATA, 12'd1023, 32'h7FFF_FFFF);
    load_word(CMD_LOAD_DATA, 12'd1024, 32'hFFFF_FFFF);
    load_word(CMD_LOAD_DATA, 12'hFFF, 32'h1234_5678);
    load_word(CMD_LOAD_CODE, 12'hFFF, 32'hFFFF_FFFF);
    load_word(CMD_LOAD_CODE, 12'd0, OP_SET);
    load_word(CMD_LOAD_CODE, 12'd1, 32'd3);
    load_word(CMD_LOAD_CODE, 12'd2, 32'h8000_0000);
    load_word(CMD_LOAD_CODE, 12'd3, OP_PUSH);
    load_word(CMD_LOAD_CODE, 12'd4, 32'd3);
    load_word(CMD_LOAD_CODE, 12'd5, OP_SET);
    load_word(CMD_LOAD_CODE, 12'd6, 32'd3);
    load_word(CMD_LOAD_CODE, 12'd7, 32'hFFFF_FFFF);
    load_word(CMD_LOAD_CODE, 12'd8, OP_DIV);
    load_word(CMD_LOAD_CODE, 12'd9, OP_PRINT);
    for (int i = 0; i < 5; i++) void'(run_step(1'b0));

    // Random programs: fresh code is planted where IP lands, or after a fault.
    while (command_q.size() < N_ITEMS) begin
      // Once, about halfway, the next step waits until every result is back.
      if (command_q.size() > N_ITEMS / 2 && !drain_used) begin
        drain_next = 1'b1;
        drain_used = 1'b1;
      end
      case ($urandom_range(0, 24))
        0, 1: load_word(CMD_LOAD_DATA,
                        ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63)),
                        pick_val());
        2: load_word(CMD_LOAD_CODE, 12'($urandom), pick_op());
        default: begin
          ip = vm_stack[0];
          fresh = !vm_code_ok[ip] || last_fault || $urandom_range(0, 6) == 0;
          for (tries = 0; tries < 4; tries++) begin
            if (fresh || tries > 0) begin
              plant(ip);
            end else begin
              for (int k = 1; k < vm_len(vm_code[ip]); k++)
                if (!vm_code_ok[ip + k]) load_word(CMD_LOAD_CODE, 12'(ip + k), pick_reg());
            end
            if (run_step(1'b1)) break;
          end
          if (tries == 4) begin
            load_word(CMD_LOAD_CODE, ip[11:0], OP_JMP);
            load_word(CMD_LOAD_CODE, ip[11:0] + 12'd1, $urandom_range(0, 3000));
            void'(run_step(1'b1));
          end
        end
      endcase
    end

    // Closing part: an instruction running off the end of code memory, then halt.
    ip = vm_stack[0];
    load_word(CMD_LOAD_CODE, ip[11:0], OP_JMP);
    load_word(CMD_LOAD_CODE, ip[11:0] + 12'd1, 32'd4094);
    void'(run_step(1'b0));
    load_word(CMD_LOAD_CODE, 12'd4094, OP_SET);
    load_word(CMD_LOAD_CODE, 12'd4095, 32'd3);
    void'(run_step(1'b0));
    load_word(CMD_LOAD_CODE, 12'd4094, OP_JMP);
    load_word(CMD_LOAD_CODE, 12'd4095, 32'd100);
    void'(run_step(1'b0));
    load_word(CMD_LOAD_CODE, 12'd100, OP_EXIT);
    void'(run_step(1'b0));
    void'(run_step(1'b0));
    load_word(CMD_LOAD_DATA, 12'd7, 32'h5555_AAAA);
    void'(run_step(1'b0));
    total_beats = command_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (got_cnt != total_beats) @(posedge clk);
    repeat (60) @(posedge clk);
    if (vm_outcome_q.size() != 0) flag_mismatch("expected results never arrived");

    $display("Ran %0d beats: %0d loads, %0d executed steps (%0d faulted, %0d print events).",
             total_beats, n_load, n_exec, n_fault, n_print);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("tb_stack_vm_instruction_executor: PASS");
    end else begin
      $display("tb_stack_vm_instruction_executor: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/svie_pkg.sv
rtl/svie_ram.sv
rtl/svie_div.sv
rtl/svie_ctrl.sv
rtl/svie_dp.sv
rtl/stack_vm_instruction_executor.sv
tb/tb_stack_vm_instruction_executor.sv
